/* src/unique_id_wait_queue_macros.svh */
// Assertion macros used by the checker of the wait queue.
`ifndef UNIQUE_ID_WAIT_QUEUE_MACROS_SVH
`define UNIQUE_ID_WAIT_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UWQ_AST_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define UWQ_AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/uwq_pkg.sv */
// Types and codes of the unique identifier wait queue.
`timescale 1ns / 1ps
package uwq_pkg;

    localparam int ID_W     = 31;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int NUM_W    = 5;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [ID_W-1:0]     t_id;

    localparam t_cmd CMD_QUERY  = 2'd0;
    localparam t_cmd CMD_ADD    = 2'd1;
    localparam t_cmd CMD_REMOVE = 2'd2;
    localparam t_cmd CMD_POP    = 2'd3;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_PRESENT   = 3'd1;
    localparam t_status ST_NOT_FOUND = 3'd2;
    localparam t_status ST_EMPTY     = 3'd3;
    localparam t_status ST_FULL      = 3'd4;

    // Result item, last field in the lowest bits.
    typedef struct packed {
        logic [2:0]       pad;
        logic [NUM_W-1:0] occupancy;
        logic             head_valid;
        t_id              head_id;
        logic [NUM_W-1:0] position;
        t_status          status;
    } t_out_item;

endpackage

/* src/unique_id_wait_queue.sv */
// Top level of the unique identifier wait queue: sequencer, compare unit and cell RAM.
//
// Usage:
//   Input stream (i_s_*): one request per command. tuser carries the command
//   (query, add at tail, remove identifier, pop head), tdata the identifier.
//   Output stream (o_m_*): exactly one result per request, in order: status,
//   one-based position of the identifier after the step, head identifier with
//   its valid flag, and occupancy.
//   Sequence: a request reads and compares each cell in turn with the single
//   identifier comparator (S_RD, S_CMP) until a match or the last queued cell,
//   decides (S_EXEC), then on a remove or pop moves each later cell forward
//   (S_SHR reads the RAM, S_SHW writes it), then loads the result (S_DONE).
//   An empty queue skips the scan.
//   o_s_tready is high only while the sequencer is idle.
//   Reset empties the queue at once; cell contents are not cleared since only
//   cells below the occupancy are ever read.
//   A stalled receiver holds the result in the output register; a new request
//   may still be accepted and is worked on, but its result waits until the
//   output register drains.
`timescale 1ns / 1ps
module unique_id_wait_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,  // [30:0] attendee_id, [31] zero
    input  logic [1:0]  i_s_tuser,  // [1:0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata   // [2:0] status, [7:3] position, [38:8] head_id,
                                    // [39] head_valid, [44:40] occupancy, [47:45] zero
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_SHR  = 3'd4;
    localparam logic [2:0] S_SHW  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [IW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_pos, n_pos;
    logic [CW-1:0]        r_res_pos, n_res_pos;
    uwq_pkg::t_status     r_status, n_status;
    uwq_pkg::t_cmd        r_cmd, n_cmd;
    uwq_pkg::t_id         r_id, n_id;
    uwq_pkg::t_id         r_head, n_head;
    logic                 r_out_valid, n_out_valid;
    uwq_pkg::t_out_item   r_out, n_out;

    logic                 w_accept;
    logic                 w_we;
    logic [IW-1:0]        w_waddr;
    uwq_pkg::t_id         w_wdata;
    logic [IW-1:0]        w_raddr;
    uwq_pkg::t_id         w_rdata;
    logic [CW:0]          w_idx_ext;
    logic [CW+4:0]        w_pos_wide;
    logic [CW+4:0]        w_cnt_wide;

    uwq_ram #(
        .WIDTH(uwq_pkg::ID_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_idx_ext  = (CW + 1)'(r_idx);
    assign w_pos_wide = {5'b0, r_res_pos};
    assign w_cnt_wide = {5'b0, r_count};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_res_pos   = r_res_pos;
        n_status    = r_status;
        n_cmd       = r_cmd;
        n_id        = r_id;
        n_head      = r_head;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = w_rdata;
        w_raddr     = r_idx;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd   = i_s_tuser;
                    n_id    = i_s_tdata[uwq_pkg::ID_W-1:0];
                    n_idx   = '0;
                    n_pos   = '0;
                    n_state = (r_count == '0) ? S_EXEC : S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                // Identifiers are unique, so the first match ends the scan.
                if (w_rdata == r_id) begin
                    n_pos   = CW'(w_idx_ext + 1'b1);
                    n_state = S_EXEC;
                end else if (w_idx_ext + 1'b1 == (CW + 1)'(r_count)) begin
                    n_state = S_EXEC;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RD;
                end
            end
            S_EXEC: begin
                n_status  = uwq_pkg::ST_OK;
                n_res_pos = r_pos;
                n_state   = S_DONE;
                case (r_cmd)
                    uwq_pkg::CMD_QUERY: begin
                        if (r_pos == '0) begin
                            n_status = uwq_pkg::ST_NOT_FOUND;
                        end
                    end
                    uwq_pkg::CMD_ADD: begin
                        if (r_pos != '0) begin
                            n_status = uwq_pkg::ST_PRESENT;
                        end else if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_status = uwq_pkg::ST_FULL;
                        end else begin
                            w_we      = 1'b1;
                            w_waddr   = r_count[IW-1:0];
                            w_wdata   = r_id;
                            n_count   = r_count + 1'b1;
                            n_res_pos = r_count + 1'b1;
                            if (r_count == '0) begin
                                n_head = r_id;
                            end
                        end
                    end
                    uwq_pkg::CMD_REMOVE: begin
                        if (r_pos == '0) begin
                            n_status = uwq_pkg::ST_NOT_FOUND;
                        end else begin
                            n_res_pos = '0;
                            n_idx     = IW'(r_pos - 1'b1);
                            if (r_pos < r_count) begin
                                n_state = S_SHR;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                    end
                    default: begin
                        if (r_count == '0) begin
                            n_status = uwq_pkg::ST_EMPTY;
                        end else begin
                            // The popped head shifts everyone one place forward.
                            n_res_pos = (r_pos > CW'(1)) ? r_pos - 1'b1 : '0;
                            n_idx     = '0;
                            if (r_count > CW'(1)) begin
                                n_state = S_SHR;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                    end
                endcase
            end
            S_SHR: begin
                w_raddr = r_idx + 1'b1;
                n_state = S_SHW;
            end
            S_SHW: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = w_rdata;
                if (r_idx == '0) begin
                    n_head = w_rdata;
                end
                if (w_idx_ext + 2'd2 < (CW + 1)'(r_count)) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SHR;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid        = 1'b1;
                    n_out.pad          = '0;
                    n_out.status       = r_status;
                    n_out.position     = w_pos_wide[uwq_pkg::NUM_W-1:0];
                    n_out.head_valid   = (r_count != '0);
                    n_out.head_id      = (r_count != '0) ? r_head : '0;
                    n_out.occupancy    = w_cnt_wide[uwq_pkg::NUM_W-1:0];
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_res_pos <= n_res_pos;
        r_status  <= n_status;
        r_cmd     <= n_cmd;
        r_id      <= n_id;
        r_head    <= n_head;
        r_out     <= n_out;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

endmodule

/* src/uwq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module uwq_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/uwq_chk.sv */
// Port-level checker of the wait queue, bound to the top level.
`timescale 1ns / 1ps
`include "unique_id_wait_queue_macros.svh"
module uwq_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata
);

    uwq_pkg::t_out_item w_out;

    assign w_out = o_m_tdata;

    `UWQ_AST_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "result dropped or changed while stalled")
    `UWQ_AST_NEXT(a_busy_after_req, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "request taken while the previous one is in work")
    `UWQ_AST_SAME(a_head_flag, i_clk, i_rst_n, o_m_tvalid, w_out.head_valid == (w_out.occupancy != '0), "head flag disagrees with occupancy")
    `UWQ_AST_SAME(a_head_zero, i_clk, i_rst_n, o_m_tvalid && !w_out.head_valid, w_out.head_id == '0, "empty queue shows a head identifier")
    `UWQ_AST_SAME(a_absent_pos, i_clk, i_rst_n, o_m_tvalid && w_out.status == uwq_pkg::ST_NOT_FOUND, w_out.position == '0, "absent identifier reports a position")

endmodule

bind unique_id_wait_queue uwq_chk u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata)
);

/* tb/sv/tb.sv */
// Self-checking testbench for the unique identifier wait queue.
`timescale 1ns / 1ps
module tb;
    import uwq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int POOL_SIZE   = 24;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 4 * QUEUE_DEPTH + 8;

    // Idle modes of the two stream sides.
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // Command mixes of the random phases.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN
    } t_cmd_mix;

    typedef struct {
        t_cmd cmd;
        t_id  id;
    } t_request;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;  // [30:0] attendee_id, [31] zero
    logic [1:0]  i_s_tuser  = '0;  // [1:0] cmd
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;        // [2:0] status, [7:3] position, [38:8] head_id,
                                   // [39] head_valid, [44:40] occupancy, [47:45] zero

    t_request   pending_reqs[$];
    t_out_item  expected_results[$];
    t_id        shadow_cells[$];
    t_id        id_pool[POOL_SIZE];
    t_idle_mode idle_mode = IDLE_NONE;
    logic       hold_go   = 1'b0;
    logic       rx_hold   = 1'b0;
    int         errors    = 0;
    int         n_accepted = 0;
    int         n_checked  = 0;
    int         status_seen[5] = '{default: 0};

    unique_id_wait_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One-based position among the queued cells, 0 if absent.
    function automatic logic [NUM_W-1:0] locate_id(t_id id);
        for (int i = 0; i < shadow_cells.size(); i++) begin
            if (shadow_cells[i] == id) begin
                return NUM_W'(i + 1);
            end
        end
        return '0;
    endfunction

    // Apply one request to the shadow queue and return the result it yields.
    function automatic t_out_item apply_request(t_cmd cmd, t_id id);
        t_out_item        res;
        logic [NUM_W-1:0] pos;
        res        = '0;
        res.status = ST_OK;
        pos        = locate_id(id);
        case (cmd)
            CMD_QUERY: begin
                if (pos == 0) res.status = ST_NOT_FOUND;
            end
            CMD_ADD: begin
                if (pos != 0) begin
                    res.status = ST_PRESENT;
                end else if (shadow_cells.size() >= QUEUE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_cells.push_back(id);
                end
            end
            CMD_REMOVE: begin
                if (pos == 0) res.status = ST_NOT_FOUND;
                else shadow_cells.delete(pos - 1);
            end
            default: begin
                if (shadow_cells.size() == 0) res.status = ST_EMPTY;
                else shadow_cells.delete(0);
            end
        endcase
        res.position   = locate_id(id);
        res.head_valid = (shadow_cells.size() != 0);
        res.head_id    = (shadow_cells.size() != 0) ? shadow_cells[0] : '0;
        res.occupancy  = NUM_W'(shadow_cells.size());
        return res;
    endfunction

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SENDER: return ($urandom_range(99) < 64);
            IDLE_BOTH:   return ($urandom_range(99) < 25);
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return ($urandom_range(99) < 64);
            IDLE_BOTH:     return ($urandom_range(99) < 25);
            default:       return 1'b0;
        endcase
    endfunction

    // Driver: hold a request until accepted, then present the next one.
    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_results.push_back(apply_request(t_cmd'(i_s_tuser), i_s_tdata[30:0]));
                void'(pending_reqs.pop_front());
                n_accepted++;
            end
            if (!(i_s_tvalid && !o_s_tready)) begin
                if (pending_reqs.size() != 0 && !sender_idles()) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {1'b0, pending_reqs[0].id};
                    i_s_tuser  <= pending_reqs[0].cmd;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest expectation.
    always @(posedge i_clk) begin : monitor
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = t_out_item'(o_m_tdata);
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: %h", o_m_tdata);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    n_checked++;
                    if (want.status <= ST_FULL) status_seen[want.status]++;
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.position !== want.position) begin
                        $error("position: expected %0d, got %0d", want.position, got.position);
                        errors++;
                    end
                    if (got.head_id !== want.head_id) begin
                        $error("head_id: expected %h, got %h", want.head_id, got.head_id);
                        errors++;
                    end
                    if (got.head_valid !== want.head_valid) begin
                        $error("head_valid: expected %0d, got %0d",
                               want.head_valid, got.head_valid);
                        errors++;
                    end
                    if (got.occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, got.occupancy);
                        errors++;
                    end
                end
            end
            i_m_tready <= !rx_hold && !receiver_stalls();
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input.
    initial begin : receiver_hold
        while (!hold_go) @(posedge i_clk);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic push_req(t_cmd cmd, t_id id);
        t_request req;
        req.cmd = cmd;
        req.id  = id;
        pending_reqs.push_back(req);
    endtask

    // Wait until every request is sent and has its result.
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic refill_pool();
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = t_id'($urandom());
    endtask

    task automatic run_random(int n_items, t_idle_mode mode, t_cmd_mix mix);
        int   pick;
        t_cmd cmd;
        t_id  id;
        idle_mode = mode;
        refill_pool();
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(99);
            if (mix == MIX_FILL) begin
                cmd = (pick < 50) ? CMD_ADD : (pick < 70) ? CMD_REMOVE :
                      (pick < 80) ? CMD_POP : CMD_QUERY;
            end else begin
                cmd = (pick < 30) ? CMD_ADD : (pick < 55) ? CMD_REMOVE :
                      (pick < 80) ? CMD_POP : CMD_QUERY;
            end
            // Mostly known identifiers so that hits, duplicates and removals happen.
            id = ($urandom_range(99) < 85) ? id_pool[$urandom_range(POOL_SIZE - 1)]
                                           : t_id'($urandom());
            push_req(cmd, id);
        end
        wait_drained();
    endtask

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_mode = IDLE_NONE;
        push_req(CMD_QUERY, 31'd5);
        push_req(CMD_POP, 31'd5);
        push_req(CMD_REMOVE, 31'd5);
        push_req(CMD_ADD, 31'h0000_0000);
        push_req(CMD_ADD, 31'h7FFF_FFFF);
        push_req(CMD_ADD, 31'h0000_0000);
        push_req(CMD_QUERY, 31'h7FFF_FFFF);
        for (int i = 0; i < QUEUE_DEPTH - 2; i++) begin
            push_req(CMD_ADD, t_id'(32'h1234_5000 + i * 32'h0101_0011));
        end
        push_req(CMD_ADD, 31'd999);
        // Duplicate check wins over the full check.
        push_req(CMD_ADD, 31'h0000_0000);
        push_req(CMD_REMOVE, t_id'(32'h1234_5000 + 6 * 32'h0101_0011));
        push_req(CMD_REMOVE, 31'h0000_0000);
        push_req(CMD_POP, 31'h7FFF_FFFF);
        push_req(CMD_POP, t_id'(32'h1234_5000 + 3 * 32'h0101_0011));
        wait_drained();

        // Receiver holds off while the sender keeps offering.
        hold_go = 1'b1;
        run_random(150, IDLE_NONE, MIX_FILL);

        for (int pass = 0; pass < 2; pass++) begin
            run_random(172, IDLE_NONE, (pass == 0) ? MIX_FILL : MIX_DRAIN);
            run_random(172, IDLE_SENDER, MIX_DRAIN);
            run_random(172, IDLE_RECEIVER, MIX_FILL);
            run_random(172, IDLE_BOTH, (pass == 0) ? MIX_DRAIN : MIX_FILL);
        end

        idle_mode = IDLE_NONE;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked under four idle modes",
                 n_accepted, n_checked);
        $display("outcomes: ok %0d, duplicate %0d, not found %0d, empty pop %0d, full %0d",
                 status_seen[ST_OK], status_seen[ST_PRESENT], status_seen[ST_NOT_FOUND],
                 status_seen[ST_EMPTY], status_seen[ST_FULL]);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
